[hdl/vector_angle_from_origin_assert.svh]
// Assertion macros shared by the angle block.
// Each macro takes a label and a property body; the clock is aclk and
// checks are held off while aresetn is low.
`ifndef VECTOR_ANGLE_FROM_ORIGIN_ASSERT_SVH
`define VECTOR_ANGLE_FROM_ORIGIN_ASSERT_SVH

`ifndef SYNTHESIS

`define VAFO_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vafo assertion failed");

`define VAFO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vafo assertion failed");

`else

`define VAFO_ASSERT_IMPL(label, ante, cons)

`define VAFO_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hdl/vafo_pkg.sv]
`timescale 1ns / 1ps

package vafo_pkg;

    // Binary angle widths: accumulator holds 2^32 per turn, ports 2^16
    localparam int ANGLE_W = 32;
    localparam int BAM_W   = 16;

    // Accumulator start for vectors folded from the left half plane (pi)
    localparam logic [ANGLE_W-1:0] PI_ANGLE = 32'h8000_0000;

    // atan(2^-i) in accumulator units, one entry per rotation step
    localparam logic [ANGLE_W-1:0] ATAN_TABLE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Per-item side data carried alongside the rotation
    typedef struct packed {
        logic [BAM_W-1:0] origin;
        logic             zero;
    } vafo_side_t;

endpackage

[hdl/vafo_cell.sv]
`timescale 1ns / 1ps

module vafo_cell #(
    parameter int W     = 19,
    parameter int STAGE = 0
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 adv,
    input  logic                                 valid_in,
    input  logic signed [W-1:0]                  x_in,
    input  logic signed [W-1:0]                  y_in,
    input  logic [vafo_pkg::ANGLE_W-1:0]         z_in,
    input  vafo_pkg::vafo_side_t                 side_in,
    output logic                                 valid_out,
    output logic signed [W-1:0]                  x_out,
    output logic signed [W-1:0]                  y_out,
    output logic [vafo_pkg::ANGLE_W-1:0]         z_out,
    output vafo_pkg::vafo_side_t                 side_out
);
    import vafo_pkg::*;

    localparam logic [ANGLE_W-1:0] STEP_ANGLE = ATAN_TABLE[STAGE];

    logic                 valid_reg;
    logic signed [W-1:0]  x_reg, x_next;
    logic signed [W-1:0]  y_reg, y_next;
    logic [ANGLE_W-1:0]   z_reg, z_next;
    vafo_side_t           side_reg;
    logic signed [W-1:0]  x_shift, y_shift;

    // Rotate toward the x axis by one micro-angle, direction set by y sign
    always_comb begin
        x_shift = x_in >>> STAGE;
        y_shift = y_in >>> STAGE;
        if (!y_in[W-1]) begin
            x_next = x_in + y_shift;
            y_next = y_in - x_shift;
            z_next = z_in + STEP_ANGLE;
        end else begin
            x_next = x_in - y_shift;
            y_next = y_in + x_shift;
            z_next = z_in - STEP_ANGLE;
        end
    end

    // Advance valid with the chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_in;
        end
    end

    // Hold payload while the chain is frozen
    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

endmodule

[hdl/vafo_out.sv]
`timescale 1ns / 1ps
`include "vector_angle_from_origin_assert.svh"

module vafo_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          valid_in,
    input  logic [vafo_pkg::ANGLE_W-1:0]  z_in,
    input  vafo_pkg::vafo_side_t          side_in,
    output logic                          adv,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [vafo_pkg::BAM_W-1:0]    m_angle,
    output logic                          m_zero
);
    import vafo_pkg::*;

    logic              m_valid_reg;
    logic [BAM_W-1:0]  m_angle_reg;
    logic              m_zero_reg;
    logic              skid_valid_reg;
    logic [BAM_W-1:0]  skid_angle_reg;
    logic              skid_zero_reg;
    logic [BAM_W-1:0]  rounded;
    logic [BAM_W-1:0]  angle_calc;
    logic              out_free;

    // Round the accumulator to port units, subtract origin, force zero vectors
    always_comb begin
        rounded = z_in[ANGLE_W-1 -: BAM_W] + {{(BAM_W-1){1'b0}}, z_in[ANGLE_W-BAM_W-1]};
        if (side_in.zero) begin
            angle_calc = '0;
        end else begin
            angle_calc = rounded - side_in.origin;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign adv      = !skid_valid_reg;

    // Output register plus one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= valid_in;
            end
        end else if (valid_in && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Move result beats between skid and output register
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                m_angle_reg <= skid_angle_reg;
                m_zero_reg  <= skid_zero_reg;
            end else begin
                m_angle_reg <= angle_calc;
                m_zero_reg  <= side_in.zero;
            end
        end else if (!skid_valid_reg) begin
            skid_angle_reg <= angle_calc;
            skid_zero_reg  <= side_in.zero;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_angle = m_angle_reg;
    assign m_zero  = m_zero_reg;

    `VAFO_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, m_valid_reg)
    `VAFO_ASSERT_IMPL(a_zero_gives_zero, m_valid_reg && m_zero_reg, m_angle_reg == '0)
    `VAFO_ASSERT_IMPL(a_skid_fills_on_stall, $rose(skid_valid_reg), $past(m_valid_reg && !m_ready))
    `VAFO_ASSERT_NEXT(a_stall_keeps_beat, m_valid_reg && !m_ready, m_valid_reg)

endmodule

[hdl/vector_angle_from_origin.sv]
`timescale 1ns / 1ps

// Vector angle from origin: full-circle angle of a signed 2-D vector.
// Input beat (s_ channel): vec_x, vec_y and origin_angle in s_tdata. Result
// beat (m_ channel): the angle (vector angle minus origin, 65536 = one turn)
// in m_tdata, and in m_tuser a flag that is set for a zero vector, whose
// angle is then 0.
// A fold register folds the vector into the right half plane, one chain
// cell per rotation step follows, and one output register rounds and
// subtracts the origin. One beat is accepted per cycle while the receiver
// keeps up.
// When the receiver stalls, the output register holds its beat and a skid
// entry takes the next finished result; once the skid entry is full the
// chain freezes and s_tready drops until the output drains.
// Reset (aresetn low, synchronous) empties the chain, the skid entry and
// the output register; s_tready is high right after reset.
module vector_angle_from_origin #(
    parameter int COORD_WIDTH = 16,
    parameter int ITERATIONS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] vec_x, [31:16] vec_y, [47:32] origin_angle
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] angle
    output logic [15:0] m_tdata,
    // [0] zero_vector
    output logic        m_tuser
);
    import vafo_pkg::*;

    // Headroom for negation and rotation gain
    localparam int W = COORD_WIDTH + 3;

    logic                   adv;
    logic [COORD_WIDTH+15:0] wide_x, wide_y;
    logic [COORD_WIDTH-1:0] raw_x, raw_y;
    logic signed [W-1:0]    ext_x, ext_y;
    logic                   x_neg;

    logic                   valid_fold_reg;
    logic signed [W-1:0]    x_fold_reg, x_fold_next;
    logic signed [W-1:0]    y_fold_reg, y_fold_next;
    logic [ANGLE_W-1:0]     z_fold_reg, z_fold_next;
    vafo_side_t             side_fold_reg, side_fold_next;

    logic                   valid_chain [ITERATIONS+1];
    logic signed [W-1:0]    x_chain     [ITERATIONS+1];
    logic signed [W-1:0]    y_chain     [ITERATIONS+1];
    logic [ANGLE_W-1:0]     z_chain     [ITERATIONS+1];
    vafo_side_t             side_chain  [ITERATIONS+1];

    assign s_tready = adv;

    // Take the low coordinate bits and sign-extend them
    always_comb begin
        wide_x = {{COORD_WIDTH{1'b0}}, s_tdata[15:0]};
        wide_y = {{COORD_WIDTH{1'b0}}, s_tdata[31:16]};
        raw_x  = wide_x[COORD_WIDTH-1:0];
        raw_y  = wide_y[COORD_WIDTH-1:0];
        ext_x  = {{(W-COORD_WIDTH){raw_x[COORD_WIDTH-1]}}, raw_x};
        ext_y  = {{(W-COORD_WIDTH){raw_y[COORD_WIDTH-1]}}, raw_y};
        x_neg  = raw_x[COORD_WIDTH-1];
    end

    // Fold the left half plane over by pi
    always_comb begin
        if (x_neg) begin
            x_fold_next = -ext_x;
            y_fold_next = -ext_y;
            z_fold_next = PI_ANGLE;
        end else begin
            x_fold_next = ext_x;
            y_fold_next = ext_y;
            z_fold_next = '0;
        end
        side_fold_next.origin = s_tdata[47:32];
        side_fold_next.zero   = (raw_x == '0) && (raw_y == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_fold_reg <= 1'b0;
        end else if (adv) begin
            valid_fold_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_fold_reg    <= x_fold_next;
            y_fold_reg    <= y_fold_next;
            z_fold_reg    <= z_fold_next;
            side_fold_reg <= side_fold_next;
        end
    end

    assign valid_chain[0] = valid_fold_reg;
    assign x_chain[0]     = x_fold_reg;
    assign y_chain[0]     = y_fold_reg;
    assign z_chain[0]     = z_fold_reg;
    assign side_chain[0]  = side_fold_reg;

    // One rotation cell per step
    for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
        vafo_cell #(
            .W     (W),
            .STAGE (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .valid_in  (valid_chain[g]),
            .x_in      (x_chain[g]),
            .y_in      (y_chain[g]),
            .z_in      (z_chain[g]),
            .side_in   (side_chain[g]),
            .valid_out (valid_chain[g+1]),
            .x_out     (x_chain[g+1]),
            .y_out     (y_chain[g+1]),
            .z_out     (z_chain[g+1]),
            .side_out  (side_chain[g+1])
        );
    end

    vafo_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .valid_in (valid_chain[ITERATIONS]),
        .z_in     (z_chain[ITERATIONS]),
        .side_in  (side_chain[ITERATIONS]),
        .adv      (adv),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_angle  (m_tdata),
        .m_zero   (m_tuser)
    );

endmodule

[test/vector_angle_from_origin_test.sv]
`timescale 1ns / 1ps

module vector_angle_from_origin_test;

    import vafo_pkg::*;

    localparam int COORD_WIDTH  = 16;
    localparam int ITERATIONS   = 16;
    localparam int LATENCY      = ITERATIONS + 2;
    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int FLOOD_BEATS  = 80;
    localparam int IDLE_LIMIT   = 5000;

    // atan(2^-i) with 2^32 per turn
    localparam bit [31:0] ROTATION_ANGLES [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic [BAM_W-1:0] angle;
        logic             zero_vector;
    } angle_result_t;

    // Predict angles for accepted vectors and match them against result beats
    class angle_ledger;
        angle_result_t pending_angles[$];
        int            mismatches = 0;

        function angle_result_t vector_angle(logic signed [15:0] vx, logic signed [15:0] vy,
                                             logic [15:0] origin);
            longint        x;
            longint        y;
            longint        xs;
            longint        ys;
            bit [31:0]     z;
            bit [31:0]     step;
            bit [31:0]     rounded;
            int            i;
            angle_result_t res;
            x = vx;
            y = vy;
            z = '0;
            if (x == 0 && y == 0) begin
                res.angle       = '0;
                res.zero_vector = 1'b1;
                return res;
            end
            // fold the left half plane over, starting from pi
            if (x < 0) begin
                x = -x;
                y = -y;
                z = 32'h8000_0000;
            end
            for (i = 0; i < ITERATIONS; i++) begin
                step = (i < 32) ? ROTATION_ANGLES[i] : 32'd0;
                xs   = x >>> i;
                ys   = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + step;
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - step;
                end
            end
            rounded         = z + 32'h0000_8000;
            res.angle       = rounded[31:16] - origin;
            res.zero_vector = 1'b0;
            return res;
        endfunction

        function void note_vector(logic [47:0] beat);
            pending_angles.push_back(vector_angle(beat[15:0], beat[31:16], beat[47:32]));
        endfunction

        function void check_angle(logic [15:0] angle, logic zero_vector);
            angle_result_t exp_res;
            if (pending_angles.size() == 0) begin
                $error("unexpected result beat: angle=%0d zero_vector=%0d", angle, zero_vector);
                mismatches++;
                return;
            end
            exp_res = pending_angles.pop_front();
            if (angle !== exp_res.angle) begin
                $error("angle: expected %0d, actual %0d", exp_res.angle, angle);
                mismatches++;
            end
            if (zero_vector !== exp_res.zero_vector) begin
                $error("zero_vector: expected %0d, actual %0d",
                       exp_res.zero_vector, zero_vector);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_angles.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;

    angle_ledger ledger = new();
    bit          hold_request = 1'b0;
    int          idle_cycles = 0;

    vector_angle_from_origin #(
        .COORD_WIDTH (COORD_WIDTH),
        .ITERATIONS  (ITERATIONS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Offer one beat and hold it until it is taken
    task automatic send_beat(logic signed [15:0] vx, logic signed [15:0] vy,
                             logic [15:0] origin);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {origin, vy, vx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ledger.note_vector(s_tdata);
    endtask

    // Drop valid for a number of cycles, with junk on the data bus
    task automatic pause_sender(int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tdata  = 48'({$urandom, $urandom});
        end
    endtask

    // Mostly full-range vectors, with small, axis, diagonal and zero vectors mixed in
    task automatic pick_vector(output logic signed [15:0] vx, output logic signed [15:0] vy);
        int        kind;
        bit [15:0] mag;
        kind = $urandom_range(0, 19);
        mag  = 16'($urandom);
        if (kind == 0) begin
            vx = '0;
            vy = '0;
        end else if (kind <= 3) begin
            vx = 16'($urandom_range(0, 8) - 4);
            vy = 16'($urandom_range(0, 8) - 4);
        end else if (kind <= 5) begin
            case ($urandom_range(0, 3))
                0: begin vx = mag; vy = '0;   end
                1: begin vx = '0;  vy = mag;  end
                2: begin vx = mag; vy = mag;  end
                default: begin vx = mag; vy = -mag; end
            endcase
        end else begin
            vx = 16'($urandom);
            vy = 16'($urandom);
        end
    endtask

    // Check every result beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            ledger.check_angle(m_tdata, m_tuser);
        end
    end

    // Watchdog: count cycles with no beat moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: phases of random stall patterns, plus one long hold-off on request
    initial begin
        int mode;
        int span;
        int phase;
        int hold_left;
        m_tready  = 1'b0;
        hold_left = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 120);
            for (phase = 0; phase < span; phase++) begin
                @(negedge aclk);
                if (hold_request) begin
                    hold_request = 1'b0;
                    hold_left    = HOLD_CYCLES;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    m_tready = 1'b0;
                end else begin
                    case (mode)
                        0: m_tready = 1'b1;
                        1: m_tready = ($urandom_range(0, 3) != 0);
                        2: m_tready = 1'($urandom_range(0, 1));
                        default: m_tready = ((phase % 4) != 3);
                    endcase
                end
            end
        end
    end

    // Stimulus
    initial begin
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        int                 n;
        int                 burst_left;
        int                 flood_left;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        burst_left = 0;
        flood_left = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // zero vector, whatever the origin
        send_beat(16'sd0, 16'sd0, 16'h0000);
        send_beat(16'sd0, 16'sd0, 16'hFFFF);
        // axes, including the negative x axis (pi)
        send_beat(16'sd32767, 16'sd0, 16'h0000);
        send_beat(-16'sd32768, 16'sd0, 16'h0000);
        send_beat(-16'sd1, 16'sd0, 16'h8000);
        send_beat(16'sd0, 16'sd32767, 16'hFFFF);
        send_beat(16'sd0, -16'sd32768, 16'h0001);
        send_beat(16'sd1, 16'sd0, 16'hFFFF);
        send_beat(16'sd0, 16'sd1, 16'h0000);
        send_beat(16'sd0, -16'sd1, 16'h4000);
        // corners and diagonals
        send_beat(-16'sd32768, -16'sd32768, 16'h0000);
        send_beat(16'sd32767, 16'sd32767, 16'hFFFF);
        send_beat(-16'sd32768, 16'sd32767, 16'h8000);
        send_beat(16'sd32767, -16'sd32768, 16'h0000);
        send_beat(-16'sd1, -16'sd1, 16'hFFFF);
        send_beat(16'sd1, -16'sd1, 16'h0000);
        send_beat(-16'sd1, 16'sd1, 16'h2000);
        // results that wrap below zero or past a turn
        send_beat(16'sd100, 16'sd1, 16'hFFFF);
        send_beat(16'sd100, -16'sd1, 16'h0001);
        send_beat(-16'sd32768, -16'sd1, 16'h8000);
        send_beat(16'sd12345, -16'sd23456, 16'(32'($urandom)));

        // random part with bursts and gaps; one flood while the receiver holds off
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT) begin
                hold_request = 1'b1;
                flood_left   = FLOOD_BEATS;
            end
            pick_vector(vx, vy);
            send_beat(vx, vy, 16'($urandom));
            if (flood_left > 0) begin
                flood_left--;
            end else if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
            end else begin
                burst_left--;
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b0;

        // drain, then let the pipeline settle
        while (ledger.outstanding() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
        if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/vafo_pkg.sv
hdl/vafo_cell.sv
hdl/vafo_out.sv
hdl/vector_angle_from_origin.sv
test/vector_angle_from_origin_test.sv
